// File: rtl/dloq_pkg.sv
// Package for the deadline-ordered input queue: shared constants, register
// indexes, controller state type and the command/status structs.
// No dependencies; every other file in rtl/ refers to it by scoped names.
package dloq_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int DEFAULT_QUEUE_DEPTH   = 16;
  localparam int DEFAULT_DEADLINE_BITS = 48;
  localparam int DEFAULT_TAG_BITS      = 16;

  // Fixed field widths.
  localparam int VC_BITS        = 4;
  localparam int REQ_INDEX_BITS = 8;
  localparam int PORT_BITS      = 8;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 8;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_QUEUE_VC        = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_REQUESTER_INDEX = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CROSSBAR_PORT   = 2'd2;

  // Event codes carried on func.
  localparam logic FUNC_ARRIVAL  = 1'b0;
  localparam logic FUNC_RESPONSE = 1'b1;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EXEC
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // latch the incoming event
    logic commit;  // update the queue and the result registers
    logic insert;  // place the latched flit in deadline order
    logic pop;     // remove the head and inject it
    logic drop;    // arrival discarded on a full queue
    logic gerr;    // grant on an empty queue or wrong channel
    logic req;     // raise a crossbar request with the new head
  } dloq_cmd_t;

  // Status from the datapath to the controller, about the latched event.
  typedef struct packed {
    logic func;
    logic granted;
    logic vc_match;
    logic empty;
    logic full;
    logic multi;   // more than one entry held
  } dloq_status_t;

endpackage

// File: rtl/deadline_ordered_input_queue.sv
// Top level of the deadline-ordered input queue for single-flit packets.
// Depends on dloq_pkg and instantiates dloq_ctrl and dloq_datapath.
//
// Usage: each event (a flit arrival or a scheduler response, chosen by
// func) is presented with start; it is taken at the rising edge where start
// is high and busy is low. Busy is high for the one cycle in which the event
// is applied to the queue, so no new event is taken until it has been applied.
// Each event produces exactly one result transfer: all result ports are
// registered from the apply state and done is high for exactly one cycle.
// The receiver cannot stall; the result ports hold their values
// until the next result, but are only meaningful while done is high.
// The queue is a row of cells kept sorted by deadline, head first. An
// arrival is placed by comparing its deadline against every cell at once,
// so the time an event takes does not depend on occupancy; it is set by the
// controller's accept/apply sequence. A valid grant shifts the row toward the head.
// The configuration registers (queue_vc, requester_index, crossbar_port) are
// written through cfg_write/cfg_index/cfg_data at any edge, and are meant to
// change only while no event is in flight.
// Synchronous reset empties the queue, clears the configuration registers
// and returns the controller to idle; no clearing pass is needed.
module deadline_ordered_input_queue #(
  parameter int QUEUE_DEPTH   = dloq_pkg::DEFAULT_QUEUE_DEPTH,
  parameter int DEADLINE_BITS = dloq_pkg::DEFAULT_DEADLINE_BITS,
  parameter int TAG_BITS      = dloq_pkg::DEFAULT_TAG_BITS,
  localparam int CountBits    = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  output logic                                done,
  input  logic                                cfg_write,
  input  logic [dloq_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [dloq_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                func,
  input  logic [DEADLINE_BITS-1:0]            flit_deadline,
  input  logic [TAG_BITS-1:0]                 flit_tag,
  input  logic                                granted,
  input  logic [dloq_pkg::VC_BITS-1:0]        grant_vc,
  output logic                                inject_valid,
  output logic [TAG_BITS-1:0]                 inject_tag,
  output logic [DEADLINE_BITS-1:0]            inject_deadline,
  output logic [dloq_pkg::PORT_BITS-1:0]      inject_port,
  output logic                                request_valid,
  output logic [DEADLINE_BITS-1:0]            request_deadline,
  output logic [dloq_pkg::REQ_INDEX_BITS-1:0] request_index,
  output logic [dloq_pkg::VC_BITS-1:0]        request_vc,
  output logic                                dropped,
  output logic                                grant_error,
  output logic [CountBits-1:0]                occupancy
);

  dloq_pkg::dloq_cmd_t    cmd;
  dloq_pkg::dloq_status_t status;

  // The controller sequences each event; the datapath holds the queue, configuration and result state.
  dloq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  dloq_datapath #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .DEADLINE_BITS (DEADLINE_BITS),
    .TAG_BITS      (TAG_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .func             (func),
    .flit_deadline    (flit_deadline),
    .flit_tag         (flit_tag),
    .granted          (granted),
    .grant_vc         (grant_vc),
    .inject_valid     (inject_valid),
    .inject_tag       (inject_tag),
    .inject_deadline  (inject_deadline),
    .inject_port      (inject_port),
    .request_valid    (request_valid),
    .request_deadline (request_deadline),
    .request_index    (request_index),
    .request_vc       (request_vc),
    .dropped          (dropped),
    .grant_error      (grant_error),
    .occupancy        (occupancy)
  );

  // Every accepted event yields its result strobe after the apply state.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |-> ##2 done)
    else $error("result strobe missing after an accepted event");

  // One result per event: the strobe is never high in back-to-back cycles.
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe repeated");

  // A drop only happens with the queue full, and leaves it full.
  assert property (@(posedge clk) disable iff (rst)
                   (done && dropped) |-> (occupancy == CountBits'(QUEUE_DEPTH)))
    else $error("arrival dropped while the queue had room");

  // A rejected grant never injects.
  assert property (@(posedge clk) disable iff (rst)
                   (done && grant_error) |-> !inject_valid)
    else $error("injection alongside a grant error");

  // Occupancy never exceeds the queue depth.
  assert property (@(posedge clk) disable iff (rst)
                   done |-> (occupancy <= CountBits'(QUEUE_DEPTH)))
    else $error("occupancy above queue depth");

endmodule

// File: rtl/dloq_ctrl.sv
// Controller state machine of the deadline-ordered input queue.
// Depends on dloq_pkg; drives dloq_datapath through dloq_cmd_t.
module dloq_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  dloq_pkg::dloq_status_t status,
  output dloq_pkg::dloq_cmd_t    cmd,
  output logic                  busy,
  output logic                  done
);

  dloq_pkg::ctrl_state_t state;
  dloq_pkg::ctrl_state_t state_next;

  logic arrival;
  logic grant;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dloq_pkg::ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.commit;
    end
  end

  assign arrival = (status.func == dloq_pkg::FUNC_ARRIVAL);
  assign grant   = (status.func == dloq_pkg::FUNC_RESPONSE) && status.granted;

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b0;
    case (state)
      dloq_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = dloq_pkg::ST_EXEC;
        end
      end
      dloq_pkg::ST_EXEC: begin
        busy       = 1'b1;
        cmd.commit = 1'b1;
        cmd.insert = arrival && !status.full;
        cmd.drop   = arrival && status.full;
        cmd.pop    = grant && !status.empty && status.vc_match;
        cmd.gerr   = grant && (status.empty || !status.vc_match);
        if (arrival) begin
          cmd.req = status.empty;
        end else if (cmd.pop) begin
          cmd.req = status.multi;
        end else begin
          cmd.req = !status.empty;
        end
        state_next = dloq_pkg::ST_IDLE;
      end
      default: begin
        state_next = dloq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/dloq_datapath.sv
// Datapath of the deadline-ordered input queue: event latch, configuration
// registers, the sorted row of queue cells and the result registers.
// Depends on dloq_pkg; commanded by dloq_ctrl.
module dloq_datapath #(
  parameter int QUEUE_DEPTH   = dloq_pkg::DEFAULT_QUEUE_DEPTH,
  parameter int DEADLINE_BITS = dloq_pkg::DEFAULT_DEADLINE_BITS,
  parameter int TAG_BITS      = dloq_pkg::DEFAULT_TAG_BITS,
  localparam int CountBits    = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  dloq_pkg::dloq_cmd_t                 cmd,
  output dloq_pkg::dloq_status_t              status,
  input  logic                                cfg_write,
  input  logic [dloq_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [dloq_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                func,
  input  logic [DEADLINE_BITS-1:0]            flit_deadline,
  input  logic [TAG_BITS-1:0]                 flit_tag,
  input  logic                                granted,
  input  logic [dloq_pkg::VC_BITS-1:0]        grant_vc,
  output logic                                inject_valid,
  output logic [TAG_BITS-1:0]                 inject_tag,
  output logic [DEADLINE_BITS-1:0]            inject_deadline,
  output logic [dloq_pkg::PORT_BITS-1:0]      inject_port,
  output logic                                request_valid,
  output logic [DEADLINE_BITS-1:0]            request_deadline,
  output logic [dloq_pkg::REQ_INDEX_BITS-1:0] request_index,
  output logic [dloq_pkg::VC_BITS-1:0]        request_vc,
  output logic                                dropped,
  output logic                                grant_error,
  output logic [CountBits-1:0]                occupancy
);

  // Configuration registers.
  logic [dloq_pkg::VC_BITS-1:0]        queue_vc;
  logic [dloq_pkg::REQ_INDEX_BITS-1:0] requester_index;
  logic [dloq_pkg::PORT_BITS-1:0]      crossbar_port;

  // Latched event.
  logic                         item_func;
  logic [DEADLINE_BITS-1:0]     item_deadline;
  logic [TAG_BITS-1:0]          item_tag;
  logic                         item_granted;
  logic [dloq_pkg::VC_BITS-1:0] item_vc;

  // Sorted cells, head at position 0.
  logic [DEADLINE_BITS-1:0] deadline_cells [QUEUE_DEPTH];
  logic [TAG_BITS-1:0]      tag_cells      [QUEUE_DEPTH];
  logic [DEADLINE_BITS-1:0] deadline_ins   [QUEUE_DEPTH];
  logic [TAG_BITS-1:0]      tag_ins        [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]   stays;
  logic [CountBits-1:0]     entry_count;
  logic [CountBits-1:0]     entry_count_next;
  logic [DEADLINE_BITS-1:0] head_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_vc        <= '0;
      requester_index <= '0;
      crossbar_port   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        dloq_pkg::REG_QUEUE_VC:        queue_vc <= cfg_data[dloq_pkg::VC_BITS-1:0];
        dloq_pkg::REG_REQUESTER_INDEX: requester_index <= cfg_data;
        dloq_pkg::REG_CROSSBAR_PORT:   crossbar_port <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_func     <= func;
      item_deadline <= flit_deadline;
      item_tag      <= flit_tag;
      item_granted  <= granted;
      item_vc       <= grant_vc;
    end
  end

  // A valid cell whose deadline is not later than the new one keeps its
  // place; this keeps equal deadlines in arrival order.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      stays[i] = (entry_count > CountBits'(i)) && (deadline_cells[i] <= item_deadline);
    end
    deadline_ins[0] = stays[0] ? deadline_cells[0] : item_deadline;
    tag_ins[0]      = stays[0] ? tag_cells[0] : item_tag;
    for (int i = 1; i < QUEUE_DEPTH; i++) begin
      if (stays[i]) begin
        deadline_ins[i] = deadline_cells[i];
        tag_ins[i]      = tag_cells[i];
      end else if (stays[i-1]) begin
        deadline_ins[i] = item_deadline;
        tag_ins[i]      = item_tag;
      end else begin
        deadline_ins[i] = deadline_cells[i-1];
        tag_ins[i]      = tag_cells[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && cmd.insert) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        deadline_cells[i] <= deadline_ins[i];
        tag_cells[i]      <= tag_ins[i];
      end
    end else if (cmd.commit && cmd.pop) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        deadline_cells[i] <= deadline_cells[i+1];
        tag_cells[i]      <= tag_cells[i+1];
      end
    end
  end

  always_comb begin
    entry_count_next = entry_count;
    head_next        = deadline_cells[0];
    if (cmd.insert) begin
      entry_count_next = entry_count + CountBits'(1);
      head_next        = deadline_ins[0];
    end else if (cmd.pop) begin
      entry_count_next = entry_count - CountBits'(1);
      head_next        = deadline_cells[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cmd.commit) begin
      entry_count <= entry_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      inject_valid     <= cmd.pop;
      inject_tag       <= cmd.pop ? tag_cells[0] : '0;
      inject_deadline  <= cmd.pop ? deadline_cells[0] : '0;
      inject_port      <= cmd.pop ? crossbar_port : '0;
      request_valid    <= cmd.req;
      request_deadline <= cmd.req ? head_next : '0;
      request_index    <= cmd.req ? requester_index : '0;
      request_vc       <= (cmd.req || cmd.pop) ? queue_vc : '0;
      dropped          <= cmd.drop;
      grant_error      <= cmd.gerr;
      occupancy        <= entry_count_next;
    end
  end

  assign status.func     = item_func;
  assign status.granted  = item_granted;
  assign status.vc_match = (item_vc == queue_vc);
  assign status.empty    = (entry_count == '0);
  assign status.full     = (entry_count == CountBits'(QUEUE_DEPTH));
  assign status.multi    = (entry_count > CountBits'(1));

endmodule
